// ----- rtl/core/go_to_goal_heading_controller_unit_macros.svh -----
// Assertion helpers for the checker file ggh_checker.sv.
`ifndef GO_TO_GOAL_HEADING_CONTROLLER_UNIT_MACROS_SVH
`define GO_TO_GOAL_HEADING_CONTROLLER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GGH_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle check");

// Next-cycle implication, disabled while reset is asserted.
`define GGH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle check");

`endif

// ----- rtl/core/ggh_pkg.sv -----
`timescale 1ns / 1ps

package ggh_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int TBL_LEN       = 24;
  localparam int CORDIC_N      = (CORDIC_STAGES > TBL_LEN) ? TBL_LEN : CORDIC_STAGES;
  // one root bit per step for a 33-bit sum of squares
  localparam int SQRT_STEPS    = 17;
  localparam int NSTEP         = (CORDIC_N > SQRT_STEPS) ? CORDIC_N : SQRT_STEPS;
  localparam int EXT_BITS      = 12;

  localparam logic signed [23:0] PI_Q20 = 24'sd3294199;

  localparam logic [19:0] ATAN_Q20 [TBL_LEN] = '{
    20'd823550, 20'd486170, 20'd256879, 20'd130396, 20'd65451, 20'd32757,
    20'd16383,  20'd8192,   20'd4096,   20'd2048,   20'd1024,  20'd512,
    20'd256,    20'd128,    20'd64,     20'd32,     20'd16,    20'd8,
    20'd4,      20'd2,      20'd1,      20'd0,      20'd0,     20'd0
  };

  typedef enum logic [2:0] {
    CFG_GOAL_X    = 3'd0,
    CFG_GOAL_Y    = 3'd1,
    CFG_GAIN      = 3'd2,
    CFG_SPEED_CAP = 3'd3,
    CFG_STOP_DIST = 3'd4,
    CFG_TURN_THR  = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic signed [15:0] goal_x;
    logic signed [15:0] goal_y;
    logic [14:0]        speed_gain;
    logic [14:0]        speed_cap;
    logic [14:0]        stop_dist;
    logic [14:0]        turn_thr;
  } cfg_t;

  // CORDIC vector/angle plus square-root remainder/root, carried per item
  typedef struct packed {
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [23:0] cz;
    logic [32:0]        sn;
    logic [33:0]        sr;
    logic signed [15:0] hd;
  } iter_t;

endpackage

// ----- rtl/core/ggh_front.sv -----
`timescale 1ns / 1ps

module ggh_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ggh_pkg::cfg_t      cfg_i,
  input  logic               valid_i,
  output logic               ready_o,
  input  logic signed [15:0] pose_x_i,
  input  logic signed [15:0] pose_y_i,
  input  logic signed [15:0] heading_i,
  output logic               valid_o,
  input  logic               ready_i,
  output ggh_pkg::iter_t     data_o
);

  logic               v0_q, v1_q, v2_q;
  logic               en0, en1, en2;
  logic signed [16:0] dx0_q, dy0_q, dx1_q, dy1_q;
  logic signed [15:0] hd0_q, hd1_q;
  logic [31:0]        sqx_q, sqy_q;
  logic signed [33:0] sqx_full, sqy_full;
  logic signed [16:0] dx_d, dy_d, ax, ny;
  ggh_pkg::iter_t     out_d, out_q;

  assign en2     = !v2_q || ready_i;
  assign en1     = !v1_q || en2;
  assign en0     = !v0_q || en1;
  assign ready_o = en0;
  assign valid_o = v2_q;
  assign data_o  = out_q;

  assign dx_d = 17'(cfg_i.goal_x) - 17'(pose_x_i);
  assign dy_d = 17'(cfg_i.goal_y) - 17'(pose_y_i);

  assign sqx_full = dx0_q * dx0_q;
  assign sqy_full = dy0_q * dy0_q;

  // pre-rotate by pi when the vector points into the left half plane
  always_comb begin
    ax = dx1_q[16] ? -dx1_q : dx1_q;
    ny = dx1_q[16] ? -dy1_q : dy1_q;
    out_d.cx = 32'(ax) <<< ggh_pkg::EXT_BITS;
    out_d.cy = 32'(ny) <<< ggh_pkg::EXT_BITS;
    if (dx1_q[16]) begin
      out_d.cz = dy1_q[16] ? -ggh_pkg::PI_Q20 : ggh_pkg::PI_Q20;
    end else begin
      out_d.cz = '0;
    end
    out_d.sn = {1'b0, sqx_q} + {1'b0, sqy_q};
    out_d.sr = '0;
    out_d.hd = hd1_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (en0) v0_q <= valid_i;
      if (en1) v1_q <= v0_q;
      if (en2) v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en0) begin
      dx0_q <= dx_d;
      dy0_q <= dy_d;
      hd0_q <= heading_i;
    end
    if (en1) begin
      dx1_q <= dx0_q;
      dy1_q <= dy0_q;
      hd1_q <= hd0_q;
      sqx_q <= sqx_full[31:0];
      sqy_q <= sqy_full[31:0];
    end
    if (en2) begin
      out_q <= out_d;
    end
  end

endmodule

// ----- rtl/core/ggh_iter.sv -----
`timescale 1ns / 1ps

module ggh_iter (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  ggh_pkg::iter_t data_i,
  output logic           valid_o,
  input  logic           ready_i,
  output ggh_pkg::iter_t data_o
);

  localparam int N = ggh_pkg::NSTEP;

  logic [N-1:0]   vld_q;
  logic [N-1:0]   en;
  ggh_pkg::iter_t stg_q [N];

  assign ready_o = en[0];
  assign valid_o = vld_q[N-1];
  assign data_o  = stg_q[N-1];

  for (genvar k = 0; k < N; k++) begin : g_stage
    localparam int SH = (k < ggh_pkg::SQRT_STEPS) ? 2 * (ggh_pkg::SQRT_STEPS - 1 - k) : 0;
    localparam logic [33:0] SQ_BIT = 34'(1) << SH;

    logic           vin;
    logic           dn_rdy;
    ggh_pkg::iter_t din, dnx;
    logic [34:0]    trial;
    logic signed [31:0] xs, ys;

    if (k == 0) begin : g_head
      assign vin = valid_i;
      assign din = data_i;
    end else begin : g_link
      assign vin = vld_q[k-1];
      assign din = stg_q[k-1];
    end

    if (k == N - 1) begin : g_tail
      assign dn_rdy = ready_i;
    end else begin : g_mid
      assign dn_rdy = en[k+1];
    end

    assign en[k] = !vld_q[k] || dn_rdy;

    always_comb begin
      dnx   = din;
      trial = {1'b0, din.sr} + 35'(SQ_BIT);
      xs    = din.cx >>> k;
      ys    = din.cy >>> k;
      if (k < ggh_pkg::CORDIC_N) begin
        // rotate toward the x axis, accumulate the rotation angle
        if (!din.cy[31]) begin
          dnx.cx = din.cx + ys;
          dnx.cy = din.cy - xs;
          dnx.cz = din.cz + 24'(ggh_pkg::ATAN_Q20[k]);
        end else begin
          dnx.cx = din.cx - ys;
          dnx.cy = din.cy + xs;
          dnx.cz = din.cz - 24'(ggh_pkg::ATAN_Q20[k]);
        end
      end
      if (k < ggh_pkg::SQRT_STEPS) begin
        // restoring square root, one root bit
        if ({2'b0, din.sn} >= trial) begin
          dnx.sn = din.sn - trial[32:0];
          dnx.sr = (din.sr >> 1) + SQ_BIT;
        end else begin
          dnx.sr = din.sr >> 1;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en[k]) begin
        vld_q[k] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[k]) begin
        stg_q[k] <= dnx;
      end
    end
  end

endmodule

// ----- rtl/core/ggh_back.sv -----
`timescale 1ns / 1ps

module ggh_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  ggh_pkg::cfg_t  cfg_i,
  input  logic           valid_i,
  output logic           ready_o,
  input  ggh_pkg::iter_t data_i,
  output logic           valid_o,
  input  logic           stall_i,
  output logic [14:0]    linear_speed_o,
  output logic [14:0]    angular_speed_o
);

  logic               v1_q, v2_q, v3_q;
  logic               en1, en2, en3;

  // round root, bearing and heading error
  logic [16:0]        root, dist_d, dist_q;
  logic [24:0]        zr;
  logic signed [15:0] brg;
  logic signed [16:0] err;
  logic [16:0]        aerr_d, aerr_q;
  logic               stop_d, stop1_q, stop2_q;

  // pick command, form gain product
  logic               turn_d, turn_q;
  logic [31:0]        prod_d, prod_q;
  logic [14:0]        ang_d, ang_q;

  // scale, saturate and clamp
  logic [32:0]        lin_full;
  logic [14:0]        lin_sat, lin_clip;
  logic [14:0]        lin_d, angout_d, lin_q, angout_q;

  assign en3     = !v3_q || !stall_i;
  assign en2     = !v2_q || en3;
  assign en1     = !v1_q || en2;
  assign ready_o = en1;

  assign valid_o         = v3_q;
  assign linear_speed_o  = lin_q;
  assign angular_speed_o = angout_q;

  always_comb begin
    root   = data_i.sr[16:0];
    dist_d = root + 17'(data_i.sn > {16'b0, root});
    zr     = 25'(data_i.cz) + 25'd256;
    brg    = zr[24:9];
    err    = 17'(brg) - 17'(data_i.hd);
    aerr_d = err[16] ? 17'(-err) : 17'(err);
    stop_d = dist_d <= {2'b0, cfg_i.stop_dist};
  end

  always_comb begin
    turn_d = aerr_q > {2'b0, cfg_i.turn_thr};
    prod_d = {17'b0, cfg_i.speed_gain} * {15'b0, dist_q};
    ang_d  = (aerr_q > 17'd32767) ? 15'h7fff : aerr_q[14:0];
  end

  always_comb begin
    lin_full = {1'b0, prod_q} + 33'd1024;
    lin_sat  = (|lin_full[32:26]) ? 15'h7fff : lin_full[25:11];
    lin_clip = (lin_sat > cfg_i.speed_cap) ? cfg_i.speed_cap : lin_sat;
    lin_d    = '0;
    angout_d = '0;
    if (!stop2_q) begin
      if (turn_q) begin
        angout_d = ang_q;
      end else begin
        lin_d = lin_clip;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      dist_q  <= dist_d;
      aerr_q  <= aerr_d;
      stop1_q <= stop_d;
    end
    if (en2) begin
      turn_q  <= turn_d;
      prod_q  <= prod_d;
      ang_q   <= ang_d;
      stop2_q <= stop1_q;
    end
    if (en3) begin
      lin_q    <= lin_d;
      angout_q <= angout_d;
    end
  end

endmodule

// ----- rtl/core/go_to_goal_heading_controller_unit.sv -----
`timescale 1ns / 1ps
// Channel   Direction  Handshake                 Payload
// pose in   input      in_valid_i / in_stall_o   pose_x_i, pose_y_i, heading_i
// command   output     out_valid_o / out_stall_i linear_speed_o, angular_speed_o
// config    input      cfg_we_i                  cfg_idx_i, cfg_wdata_i
//
// One pose enters per cycle while in_stall_o is low; each command passes through 3 front-end
// stages, one stage per CORDIC/square-root step for 17 steps, and 3 back-end stages.
// The step count is set by the 17 root bits of the pipelined square root.
// Reset clears all valid bits and loads the register defaults.
// A stall holds only stages that are full; bubbles ahead of it still close up.

module go_to_goal_heading_controller_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [15:0] pose_x_i,
  input  logic signed [15:0] pose_y_i,
  input  logic signed [15:0] heading_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [14:0]        linear_speed_o,
  output logic [14:0]        angular_speed_o,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [15:0]        cfg_wdata_i
);

  ggh_pkg::cfg_t  cfg_q;
  logic           front_rdy, front_vld, iter_rdy, iter_vld, back_rdy;
  ggh_pkg::iter_t front_dat, iter_dat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.goal_x     <= 16'sd2048;
      cfg_q.goal_y     <= 16'sd2048;
      cfg_q.speed_gain <= 15'd2048;
      cfg_q.speed_cap  <= 15'd6144;
      cfg_q.stop_dist  <= 15'd205;
      cfg_q.turn_thr   <= 15'd410;
    end else if (cfg_we_i) begin
      case (ggh_pkg::cfg_idx_e'(cfg_idx_i))
        ggh_pkg::CFG_GOAL_X:    cfg_q.goal_x     <= cfg_wdata_i;
        ggh_pkg::CFG_GOAL_Y:    cfg_q.goal_y     <= cfg_wdata_i;
        ggh_pkg::CFG_GAIN:      cfg_q.speed_gain <= cfg_wdata_i[14:0];
        ggh_pkg::CFG_SPEED_CAP: cfg_q.speed_cap  <= cfg_wdata_i[14:0];
        ggh_pkg::CFG_STOP_DIST: cfg_q.stop_dist  <= cfg_wdata_i[14:0];
        ggh_pkg::CFG_TURN_THR:  cfg_q.turn_thr   <= cfg_wdata_i[14:0];
        default: ;
      endcase
    end
  end

  assign in_stall_o = !front_rdy;

  ggh_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .valid_i   (in_valid_i),
    .ready_o   (front_rdy),
    .pose_x_i  (pose_x_i),
    .pose_y_i  (pose_y_i),
    .heading_i (heading_i),
    .valid_o   (front_vld),
    .ready_i   (iter_rdy),
    .data_o    (front_dat)
  );

  ggh_iter u_iter (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (front_vld),
    .ready_o (iter_rdy),
    .data_i  (front_dat),
    .valid_o (iter_vld),
    .ready_i (back_rdy),
    .data_o  (iter_dat)
  );

  ggh_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .valid_i         (iter_vld),
    .ready_o         (back_rdy),
    .data_i          (iter_dat),
    .valid_o         (out_valid_o),
    .stall_i         (out_stall_i),
    .linear_speed_o  (linear_speed_o),
    .angular_speed_o (angular_speed_o)
  );

endmodule

// ----- rtl/core/ggh_checker.sv -----
`timescale 1ns / 1ps
`include "go_to_goal_heading_controller_unit_macros.svh"

module ggh_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic signed [15:0] pose_x_i,
  input logic signed [15:0] pose_y_i,
  input logic signed [15:0] heading_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [14:0]        linear_speed_o,
  input logic [14:0]        angular_speed_o,
  input logic               cfg_we_i,
  input logic [2:0]         cfg_idx_i,
  input logic [15:0]        cfg_wdata_i
);

  logic unused_ok;
  assign unused_ok = in_valid_i ^ (^pose_x_i) ^ (^pose_y_i) ^ (^heading_i) ^ cfg_we_i
                   ^ (^cfg_idx_i) ^ (^cfg_wdata_i);

  // a stalled command stays offered
  `GGH_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)

  // and keeps its payload
  `GGH_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_o && out_stall_i,
                   $stable(linear_speed_o) && $stable(angular_speed_o))

  // drive and turn are never commanded together
  `GGH_ASSERT_NOW(a_one_cmd, clk_i, rst_ni, out_valid_o,
                  linear_speed_o == 15'd0 || angular_speed_o == 15'd0)

  // with the output register empty nothing upstream can be blocked
  `GGH_ASSERT_NOW(a_no_false_stall, clk_i, rst_ni, !out_valid_o, !in_stall_o)

endmodule

bind go_to_goal_heading_controller_unit ggh_checker u_ggh_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .pose_x_i        (pose_x_i),
  .pose_y_i        (pose_y_i),
  .heading_i       (heading_i),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .linear_speed_o  (linear_speed_o),
  .angular_speed_o (angular_speed_o),
  .cfg_we_i        (cfg_we_i),
  .cfg_idx_i       (cfg_idx_i),
  .cfg_wdata_i     (cfg_wdata_i)
);

// ----- sim/ggh_command_checker.sv -----
`timescale 1ns / 1ps

module ggh_command_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic signed [15:0] pose_x_i,
  input  logic signed [15:0] pose_y_i,
  input  logic signed [15:0] heading_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic [14:0]        linear_speed_i,
  input  logic [14:0]        angular_speed_i,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [15:0]        cfg_wdata_i,
  output int                 fail_count_o,
  output int                 pending_o,
  output int                 commands_o,
  output int                 stops_o,
  output int                 turns_o,
  output int                 drives_o
);

  localparam longint HALF_TURN_Q20 = 64'sd3294199;
  localparam int     VEC_EXT_BITS  = 12;
  localparam int     STAGES        = (ggh_pkg::CORDIC_STAGES > 24) ? 24 :
                                     ggh_pkg::CORDIC_STAGES;

  typedef struct packed {
    logic [14:0] lin;
    logic [14:0] ang;
  } drive_cmd_t;

  typedef enum logic [1:0] {
    ACT_STOP,
    ACT_TURN,
    ACT_DRIVE
  } action_e;

  ggh_pkg::cfg_t regs;
  drive_cmd_t    due_cmds[$];
  drive_cmd_t    want;
  action_e       act;
  int            fails;
  int            n_cmds;
  int            n_stop;
  int            n_turn;
  int            n_drive;

  function automatic longint atan_step(input int i);
    case (i)
      0:       return 823550;
      1:       return 486170;
      2:       return 256879;
      3:       return 130396;
      4:       return 65451;
      5:       return 32757;
      6:       return 16383;
      7:       return 8192;
      8:       return 4096;
      9:       return 2048;
      10:      return 1024;
      11:      return 512;
      12:      return 256;
      13:      return 128;
      14:      return 64;
      15:      return 32;
      16:      return 16;
      17:      return 8;
      18:      return 4;
      19:      return 2;
      20:      return 1;
      default: return 0;
    endcase
  endfunction

  // Round-to-nearest square root; the sum of squares stays below 2^34.
  function automatic longint unsigned rounded_root(input longint unsigned s);
    longint unsigned r;
    longint unsigned t;
    int              b;
    r = 0;
    for (b = 17; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= s) r = t;
    end
    if (s - r * r > r) r = r + 1;
    return r;
  endfunction

  // Vectoring rotation, angle in Q.20 radians.
  function automatic longint bearing_q20(input longint dx, input longint dy);
    longint x;
    longint y;
    longint z;
    longint xs;
    longint ys;
    int     i;
    if (dx == 0 && dy == 0) return 0;
    if (dx < 0) begin
      // fold the left half-plane over by half a turn
      x = -dx;
      y = -dy;
      z = (dy >= 0) ? HALF_TURN_Q20 : -HALF_TURN_Q20;
    end else begin
      x = dx;
      y = dy;
      z = 0;
    end
    x = x * (64'sd1 << VEC_EXT_BITS);
    y = y * (64'sd1 << VEC_EXT_BITS);
    for (i = 0; i < STAGES; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z = z + atan_step(i);
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - atan_step(i);
      end
    end
    return z;
  endfunction

  function automatic drive_cmd_t steer(input ggh_pkg::cfg_t c, input logic signed [15:0] px,
                                       input logic signed [15:0] py,
                                       input logic signed [15:0] hd, output action_e a);
    longint          dx;
    longint          dy;
    longint          bearing;
    longint          err;
    longint unsigned reach;
    longint unsigned aerr;
    longint unsigned lin;
    drive_cmd_t      cmd;
    dx      = longint'(c.goal_x) - longint'(px);
    dy      = longint'(c.goal_y) - longint'(py);
    reach   = rounded_root(dx * dx + dy * dy);
    bearing = (bearing_q20(dx, dy) + 256) >>> 9;
    err     = bearing - longint'(hd);
    aerr    = (err < 0) ? -err : err;
    cmd     = '0;
    a       = ACT_STOP;
    if (reach > c.stop_dist) begin
      if (aerr > c.turn_thr) begin
        a       = ACT_TURN;
        cmd.ang = (aerr > 32767) ? 15'h7fff : aerr[14:0];
      end else begin
        a   = ACT_DRIVE;
        lin = (c.speed_gain * reach + 1024) >> 11;
        if (lin > 32767) lin = 32767;
        if (lin > c.speed_cap) lin = c.speed_cap;
        cmd.lin = lin[14:0];
      end
    end
    return cmd;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs.goal_x     = 16'sd2048;
      regs.goal_y     = 16'sd2048;
      regs.speed_gain = 15'd2048;
      regs.speed_cap  = 15'd6144;
      regs.stop_dist  = 15'd205;
      regs.turn_thr   = 15'd410;
      due_cmds.delete();
      fails   = 0;
      n_cmds  = 0;
      n_stop  = 0;
      n_turn  = 0;
      n_drive = 0;
    end else begin
      if (cfg_we_i) begin
        case (ggh_pkg::cfg_idx_e'(cfg_idx_i))
          ggh_pkg::CFG_GOAL_X:    regs.goal_x     = cfg_wdata_i;
          ggh_pkg::CFG_GOAL_Y:    regs.goal_y     = cfg_wdata_i;
          ggh_pkg::CFG_GAIN:      regs.speed_gain = cfg_wdata_i[14:0];
          ggh_pkg::CFG_SPEED_CAP: regs.speed_cap  = cfg_wdata_i[14:0];
          ggh_pkg::CFG_STOP_DIST: regs.stop_dist  = cfg_wdata_i[14:0];
          ggh_pkg::CFG_TURN_THR:  regs.turn_thr   = cfg_wdata_i[14:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        due_cmds.push_back(steer(regs, pose_x_i, pose_y_i, heading_i, act));
        case (act)
          ACT_STOP: n_stop++;
          ACT_TURN: n_turn++;
          default:  n_drive++;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        n_cmds++;
        if (due_cmds.size() == 0) begin
          fails++;
          $error("command transfer with none outstanding: linear_speed %0d angular_speed %0d",
                 linear_speed_i, angular_speed_i);
        end else begin
          want = due_cmds.pop_front();
          if (linear_speed_i !== want.lin) begin
            fails++;
            $error("linear_speed: expected %0d, actual %0d", want.lin, linear_speed_i);
          end
          if (angular_speed_i !== want.ang) begin
            fails++;
            $error("angular_speed: expected %0d, actual %0d", want.ang, angular_speed_i);
          end
        end
      end
    end
    fail_count_o <= fails;
    pending_o    <= due_cmds.size();
    commands_o   <= n_cmds;
    stops_o      <= n_stop;
    turns_o      <= n_turn;
    drives_o     <= n_drive;
  end

endmodule

// ----- sim/go_to_goal_heading_controller_unit_tb.sv -----
`timescale 1ns / 1ps

module go_to_goal_heading_controller_unit_tb;

  localparam int         IDLE_LIMIT   = 1500;
  localparam int         TAIL_CYCLES  = 40;
  localparam int         RAND_PHASES  = 12;
  localparam int         PHASE_POSES  = 150;
  localparam logic [2:0] IDX_SPARE_LO = 3'd6;
  localparam logic [2:0] IDX_SPARE_HI = 3'd7;

  logic               clk;
  logic               rst_n       = 1'b0;
  logic               in_valid    = 1'b0;
  logic               in_stall;
  logic signed [15:0] pose_x      = '0;
  logic signed [15:0] pose_y      = '0;
  logic signed [15:0] heading     = '0;
  logic               out_valid;
  logic               out_stall   = 1'b0;
  logic [14:0]        linear_speed;
  logic [14:0]        angular_speed;
  logic               cfg_we      = 1'b0;
  logic [2:0]         cfg_idx     = '0;
  logic [15:0]        cfg_wdata   = '0;

  int            fail_count;
  int            pending;
  int            commands;
  int            stops;
  int            turns;
  int            drives;
  int            poses_sent;
  int            settings;
  bit            steady;
  ggh_pkg::cfg_t cur;

  go_to_goal_heading_controller_unit dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .pose_x_i        (pose_x),
    .pose_y_i        (pose_y),
    .heading_i       (heading),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .linear_speed_o  (linear_speed),
    .angular_speed_o (angular_speed),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata)
  );

  ggh_command_checker u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .pose_x_i        (pose_x),
    .pose_y_i        (pose_y),
    .heading_i       (heading),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .linear_speed_i  (linear_speed),
    .angular_speed_i (angular_speed),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata),
    .fail_count_o    (fail_count),
    .pending_o       (pending),
    .commands_o      (commands),
    .stops_o         (stops),
    .turns_o         (turns),
    .drives_o        (drives)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Mostly short runs, now and then a long one.
  function automatic int pick_span();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int span_rand(input int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic ggh_pkg::cfg_t pack_cfg(input int tx, input int ty, input int g,
                                             input int m, input int s, input int t);
    ggh_pkg::cfg_t c;
    c.goal_x     = tx[15:0];
    c.goal_y     = ty[15:0];
    c.speed_gain = g[14:0];
    c.speed_cap  = m[14:0];
    c.stop_dist  = s[14:0];
    c.turn_thr   = t[14:0];
    return c;
  endfunction

  function automatic ggh_pkg::cfg_t random_cfg(input int ph);
    ggh_pkg::cfg_t c;
    int            r;
    if (ph == 3) return pack_cfg(32767, -32768, 32767, 32767, 32767, 32767);
    if (ph == 7) return pack_cfg(-32768, 32767, 0, 0, 0, 0);
    c.goal_x     = ($urandom_range(0, 1) != 0) ? 16'($urandom()) : 16'(span_rand(8192));
    c.goal_y     = ($urandom_range(0, 1) != 0) ? 16'($urandom()) : 16'(span_rand(8192));
    r            = $urandom_range(0, 9);
    c.speed_gain = (r == 0) ? 15'd0 : (r == 1) ? 15'h7fff :
                   (r < 6) ? 15'($urandom_range(0, 8192)) : 15'($urandom());
    c.speed_cap  = ($urandom_range(0, 3) == 0) ? 15'h7fff : 15'($urandom());
    c.stop_dist  = ($urandom_range(0, 4) == 0) ? 15'($urandom()) : 15'($urandom_range(0, 1024));
    c.turn_thr   = ($urandom_range(0, 4) == 0) ? 15'($urandom()) : 15'($urandom_range(0, 1500));
    return c;
  endfunction

  // Heading close to the true bearing, spread around the turn threshold.
  function automatic logic signed [15:0] aim_heading(input logic signed [15:0] px,
                                                     input logic signed [15:0] py);
    int dx;
    int dy;
    int est;
    int spread;
    dx     = int'(cur.goal_x) - int'(px);
    dy     = int'(cur.goal_y) - int'(py);
    est    = (dx == 0 && dy == 0) ? 0 : $rtoi($atan2(real'(dy), real'(dx)) * 2048.0);
    spread = int'(cur.turn_thr) + 3;
    if (spread > 20000) spread = 20000;
    est = est + span_rand(spread);
    if (est > 32767) est = 32767;
    if (est < -32768) est = -32768;
    return est[15:0];
  endfunction

  task automatic next_pose(output logic signed [15:0] x, output logic signed [15:0] y,
                           output logic signed [15:0] h);
    int r;
    int sp;
    r = $urandom_range(0, 99);
    if (r < 30) begin
      x = 16'($urandom());
      y = 16'($urandom());
      h = 16'($urandom());
    end else if (r < 65) begin
      x = 16'(int'(cur.goal_x) - span_rand(1 << $urandom_range(0, 15)));
      y = 16'(int'(cur.goal_y) - span_rand(1 << $urandom_range(0, 15)));
      h = aim_heading(x, y);
    end else if (r < 80) begin
      sp = int'(cur.stop_dist) + 4;
      if (sp > 20000) sp = 20000;
      x = 16'(int'(cur.goal_x) - span_rand(sp));
      y = 16'(int'(cur.goal_y) - span_rand(sp));
      h = ($urandom_range(0, 1) != 0) ? aim_heading(x, y) : 16'($urandom());
    end else begin
      x = 16'($urandom());
      y = 16'($urandom());
      h = aim_heading(x, y);
    end
  endtask

  task automatic send_pose(input logic signed [15:0] x, input logic signed [15:0] y,
                           input logic signed [15:0] h);
    int gap;
    gap = (steady || $urandom_range(0, 99) < 55) ? 0 : pick_span();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    pose_x   <= x;
    pose_y   <= y;
    heading  <= h;
    do @(posedge clk); while (in_stall);
    poses_sent++;
  endtask

  // Drop valid and wait until every command has come back.
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic load_config(input ggh_pkg::cfg_t c, input bit spare);
    logic [2:0]  idx_q[$];
    logic [15:0] dat_q[$];
    if (spare) begin
      idx_q.push_back(IDX_SPARE_LO);
      dat_q.push_back(16'($urandom()));
      idx_q.push_back(IDX_SPARE_HI);
      dat_q.push_back(16'($urandom()));
    end
    idx_q.push_back(ggh_pkg::CFG_GOAL_X);
    dat_q.push_back(c.goal_x);
    idx_q.push_back(ggh_pkg::CFG_GOAL_Y);
    dat_q.push_back(c.goal_y);
    idx_q.push_back(ggh_pkg::CFG_GAIN);
    dat_q.push_back({1'($urandom_range(0, 1)), c.speed_gain});
    idx_q.push_back(ggh_pkg::CFG_SPEED_CAP);
    dat_q.push_back({1'($urandom_range(0, 1)), c.speed_cap});
    idx_q.push_back(ggh_pkg::CFG_STOP_DIST);
    dat_q.push_back({1'($urandom_range(0, 1)), c.stop_dist});
    idx_q.push_back(ggh_pkg::CFG_TURN_THR);
    dat_q.push_back({1'($urandom_range(0, 1)), c.turn_thr});
    foreach (idx_q[k]) begin
      cfg_we    <= 1'b1;
      cfg_idx   <= idx_q[k];
      cfg_wdata <= dat_q[k];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    cur = c;
    settings++;
  endtask

  // Random stall on the command side; none while steady.
  initial begin
    int  run_left;
    bit  stall_now;
    run_left  = 0;
    stall_now = 1'b0;
    forever begin
      @(posedge clk);
      if (steady) begin
        run_left  = 0;
        stall_now = 1'b0;
      end else if (run_left == 0) begin
        stall_now = ($urandom_range(0, 99) < 35);
        run_left  = stall_now ? pick_span() : $urandom_range(1, 8);
      end
      if (run_left > 0) run_left--;
      out_stall <= stall_now;
    end
  end

  initial begin
    int idle;
    idle = 0;
    do begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) idle = 0;
      else idle++;
    end while (idle < IDLE_LIMIT);
    $display("watchdog: no transfer for %0d cycles, %0d commands outstanding",
             IDLE_LIMIT, pending);
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    logic signed [15:0] px;
    logic signed [15:0] py;
    logic signed [15:0] hd;
    poses_sent = 0;
    settings   = 1;
    steady     = 1'b0;
    cur        = pack_cfg(2048, 2048, 2048, 6144, 205, 410);
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // register defaults: stop radius, turn threshold and bearing corners
    send_pose(16'sd2048, 16'sd2048, 16'sd0);
    send_pose(16'sd1843, 16'sd2048, 16'sd0);
    send_pose(16'sd1842, 16'sd2048, 16'sd0);
    send_pose(16'sd0, 16'sd2048, -16'sd410);
    send_pose(16'sd0, 16'sd2048, -16'sd411);
    send_pose(16'sd0, 16'sd2048, 16'sd410);
    send_pose(16'sd4096, 16'sd2048, 16'sd0);
    send_pose(16'sd4096, 16'sd2049, 16'sd0);
    send_pose(16'sd4096, 16'sd2048, -16'sd32768);
    send_pose(16'sd2048, 16'sd0, 16'sd3217);
    send_pose(16'sd2048, 16'sd4096, -16'sd3217);
    send_pose(-16'sd32768, -16'sd32768, 16'sd32767);
    send_pose(16'sd32767, 16'sd32767, -16'sd32768);
    send_pose(-16'sd8192, -16'sd8192, 16'sd1608);
    send_pose(16'sd0, 16'sd0, 16'sd1608);
    settle();

    // full-scale registers: speed product and heading error both saturate
    load_config(pack_cfg(-32768, 32767, 32767, 32767, 0, 32767), 1'b1);
    send_pose(16'sd32767, -16'sd32768, 16'sd0);
    send_pose(-16'sd32768, 16'sd32767, 16'sd0);
    send_pose(16'sd32767, -16'sd32768, -16'sd32768);
    send_pose(-16'sd32767, 16'sd32767, 16'sd0);
    settle();

    load_config(pack_cfg(0, 0, 0, 0, 0, 0), 1'b1);
    send_pose(-16'sd100, 16'sd0, 16'sd0);
    send_pose(16'sd0, 16'sd0, 16'sd0);
    send_pose(-16'sd100, 16'sd0, 16'sd1);
    settle();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      steady = (ph % 4 == 2);
      load_config(random_cfg(ph), ph[0]);
      repeat (PHASE_POSES) begin
        next_pose(px, py, hd);
        send_pose(px, py, hd);
      end
      settle();
    end
    steady = 1'b0;

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("covered %0d pose transfers and %0d command transfers over %0d register sets",
             poses_sent, commands, settings);
    $display("decisions predicted: %0d stop, %0d turn, %0d drive", stops, turns, drives);
    if (fail_count == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
